// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the keypad calculator.
// Holds nothing but macro definitions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define KPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that must also hold across reset.
`define KPC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/kpc_pkg.sv =====
// Package of the keypad calculator: widths, operator codes, key classes,
// the queue item type and the scan code decoder. No dependencies.
package kpc_pkg;

  localparam int VALUE_W = 16;
  localparam int CNT_W   = $clog2(VALUE_W);
  localparam int KEY_W   = 5;
  localparam int OP_W    = 3;
  localparam int ARG_W   = 4;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [OP_W-1:0] OP_NONE = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_DIGIT  = 3'd1,
    KIND_OPER   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_EQUALS = 3'd4
  } key_kind_t;

  // One classified key: a digit value or an operator code travels in arg.
  typedef struct packed {
    key_kind_t        kind;
    logic [ARG_W-1:0] arg;
  } kpc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kpc_qstat_t;

  // Row-major 4x4 keypad: digits in the left three columns, operators in the
  // right column, and clear, zero and equals on the bottom row.
  function automatic kpc_item_t kpc_decode(input logic [KEY_W-1:0] code);
    kpc_item_t item;
    item.kind = KIND_NONE;
    item.arg  = '0;
    case (code)
      5'd1, 5'd2, 5'd3: begin
        item.kind = KIND_DIGIT;
        item.arg  = ARG_W'(code);
      end
      5'd5, 5'd6, 5'd7: begin
        item.kind = KIND_DIGIT;
        item.arg  = ARG_W'(code - 5'd1);
      end
      5'd9, 5'd10, 5'd11: begin
        item.kind = KIND_DIGIT;
        item.arg  = ARG_W'(code - 5'd2);
      end
      5'd14: begin
        item.kind = KIND_DIGIT;
        item.arg  = '0;
      end
      5'd4: begin
        item.kind = KIND_OPER;
        item.arg  = ARG_W'(OP_ADD);
      end
      5'd8: begin
        item.kind = KIND_OPER;
        item.arg  = ARG_W'(OP_SUB);
      end
      5'd12: begin
        item.kind = KIND_OPER;
        item.arg  = ARG_W'(OP_MUL);
      end
      5'd16: begin
        item.kind = KIND_OPER;
        item.arg  = ARG_W'(OP_DIV);
      end
      5'd13: item.kind = KIND_CLEAR;
      5'd15: item.kind = KIND_EQUALS;
      default: item.kind = KIND_NONE;
    endcase
    return item;
  endfunction

endpackage

// ===== src/kpc_front.sv =====
// Front end of the keypad calculator: takes scan codes, classifies them and
// hands them to the queue. Depends on kpc_pkg.
module kpc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [kpc_pkg::KEY_W-1:0] key_code,
  input  kpc_pkg::kpc_qstat_t       q_stat,
  output logic                      push,
  output kpc_pkg::kpc_item_t        push_item
);
  import kpc_pkg::*;

  logic      slot_valid;
  kpc_item_t slot_item;
  logic      slot_load;

  assign push      = slot_valid & ~q_stat.full;
  assign in_stall  = slot_valid & q_stat.full;
  assign slot_load = in_valid & ~in_stall;
  assign push_item = slot_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (slot_load) begin
      slot_valid <= 1'b1;
    end else if (push) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_load) begin
      slot_item <= kpc_decode(key_code);
    end
  end

endmodule

// ===== src/kpc_queue.sv =====
// Short first-in first-out queue of classified keys between the front and
// back ends of the keypad calculator. Depends on kpc_pkg.
module kpc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kpc_pkg::kpc_item_t  push_item,
  input  logic                pop,
  output kpc_pkg::kpc_item_t  pop_item,
  output kpc_pkg::kpc_qstat_t q_stat
);
  import kpc_pkg::*;

  kpc_item_t       slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & ~q_stat.empty;
  assign pop_item     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/kpc_back.sv =====
// Back end of the keypad calculator: holds entry, accumulator and operator,
// runs the shift-add multiply and shift-subtract divide, and drives the
// output register. Depends on kpc_pkg.
module kpc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  kpc_pkg::kpc_qstat_t               q_stat,
  output logic                              pop,
  input  kpc_pkg::kpc_item_t                pop_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [kpc_pkg::VALUE_W-1:0] shown_value,
  output logic [kpc_pkg::OP_W-1:0]          pending_operator,
  output logic                              divide_by_zero
);
  import kpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } back_state_t;

  back_state_t        state, state_next;
  logic [VALUE_W-1:0] entry, entry_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic [OP_W-1:0]    op, op_next;
  logic [VALUE_W-1:0] wa, wa_next;
  logic [VALUE_W-1:0] wb, wb_next;
  logic [VALUE_W-1:0] wr, wr_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               neg, neg_next;
  logic               is_div, is_div_next;
  logic               divide_by_zero_next;
  logic               emit;
  logic               out_free;

  logic [VALUE_W-1:0] digit_val;
  logic [VALUE_W-1:0] add_val;
  logic [VALUE_W-1:0] sub_val;
  logic [VALUE_W-1:0] a_mag;
  logic [VALUE_W-1:0] b_mag;
  logic [VALUE_W-1:0] mul_sum;
  logic [VALUE_W:0]   rem_sh;
  logic [VALUE_W:0]   rem_diff;
  logic [VALUE_W-1:0] quo_res;
  logic [VALUE_W-1:0] result;

  assign out_free = ~out_valid | ~out_stall;
  assign pop      = (state == S_IDLE) & ~q_stat.empty & out_free;

  // entry * 10 + digit as two shifted copies and the digit
  assign digit_val = {entry[VALUE_W-4:0], 3'b000} + {entry[VALUE_W-2:0], 1'b0}
                     + VALUE_W'(pop_item.arg);
  assign add_val   = acc + entry;
  assign sub_val   = acc - entry;
  assign a_mag     = acc[VALUE_W-1] ? (~acc + 1'b1) : acc;
  assign b_mag     = entry[VALUE_W-1] ? (~entry + 1'b1) : entry;

  // One multiply step: add the shifted multiplicand when the low bit is set.
  assign mul_sum   = wb[0] ? (wr + wa) : wr;

  // One restoring divide step: bring in the next dividend bit and try the
  // divisor against the partial remainder.
  assign rem_sh    = {wr, wa[VALUE_W-1]};
  assign rem_diff  = rem_sh - {1'b0, wb};

  assign quo_res   = neg ? (~wa + 1'b1) : wa;
  assign result    = is_div ? quo_res : wr;

  always_comb begin
    state_next          = state;
    entry_next          = entry;
    acc_next            = acc;
    op_next             = op;
    wa_next             = wa;
    wb_next             = wb;
    wr_next             = wr;
    cnt_next            = cnt;
    neg_next            = neg;
    is_div_next         = is_div;
    divide_by_zero_next = 1'b0;
    emit                = 1'b0;
    case (state)
      S_IDLE: begin
        if (pop) begin
          case (pop_item.kind)
            KIND_DIGIT: begin
              entry_next = digit_val;
              emit       = 1'b1;
            end
            KIND_OPER: begin
              op_next    = pop_item.arg[OP_W-1:0];
              acc_next   = entry;
              entry_next = '0;
              emit       = 1'b1;
            end
            KIND_CLEAR: begin
              op_next    = OP_NONE;
              acc_next   = '0;
              entry_next = '0;
              emit       = 1'b1;
            end
            KIND_EQUALS: begin
              case (op)
                OP_ADD: begin
                  acc_next   = add_val;
                  entry_next = add_val;
                  emit       = 1'b1;
                end
                OP_SUB: begin
                  acc_next   = sub_val;
                  entry_next = sub_val;
                  emit       = 1'b1;
                end
                OP_MUL: begin
                  wa_next     = acc;
                  wb_next     = entry;
                  wr_next     = '0;
                  cnt_next    = CNT_W'(VALUE_W - 1);
                  is_div_next = 1'b0;
                  state_next  = S_MUL;
                end
                OP_DIV: begin
                  if (entry == '0) begin
                    divide_by_zero_next = 1'b1;
                    entry_next          = acc;
                    emit                = 1'b1;
                  end else begin
                    wa_next     = a_mag;
                    wb_next     = b_mag;
                    wr_next     = '0;
                    cnt_next    = CNT_W'(VALUE_W - 1);
                    neg_next    = acc[VALUE_W-1] ^ entry[VALUE_W-1];
                    is_div_next = 1'b1;
                    state_next  = S_DIV;
                  end
                end
                default: begin
                  entry_next = acc;
                  emit       = 1'b1;
                end
              endcase
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        wr_next  = mul_sum;
        wa_next  = {wa[VALUE_W-2:0], 1'b0};
        wb_next  = {1'b0, wb[VALUE_W-1:1]};
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        wr_next  = rem_diff[VALUE_W] ? rem_sh[VALUE_W-1:0] : rem_diff[VALUE_W-1:0];
        wa_next  = {wa[VALUE_W-2:0], ~rem_diff[VALUE_W]};
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          acc_next   = result;
          entry_next = result;
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      entry     <= '0;
      acc       <= '0;
      op        <= OP_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      entry <= entry_next;
      acc   <= acc_next;
      op    <= op_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa     <= wa_next;
    wb     <= wb_next;
    wr     <= wr_next;
    cnt    <= cnt_next;
    neg    <= neg_next;
    is_div <= is_div_next;
    if (emit) begin
      shown_value      <= $signed(entry_next);
      pending_operator <= op_next;
      divide_by_zero   <= divide_by_zero_next;
    end
  end

endmodule

// ===== src/keypad_four_function_calculator.sv =====
// Keypad calculator top level. A key that needs no multiply or divide goes through the
// front-end register and the queue and is registered at the output; multiply or divide
// on equals also runs the 16-step shared shift-add/subtract unit. Throughput: one key
// per cycle for other keys, none while a multiply or divide runs or the output stalls.
// Reset (rst, synchronous, active high) zeroes entry, accumulator and operator and
// empties the queue and output register. Depends on kpc_pkg and the kpc_* modules.
module keypad_four_function_calculator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kpc_pkg::KEY_W-1:0]         key_code,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [kpc_pkg::VALUE_W-1:0] shown_value,
  output logic [kpc_pkg::OP_W-1:0]          pending_operator,
  output logic                              divide_by_zero
);
  import kpc_pkg::*;

  // The front end registers each accepted transaction once it has been
  // classified into digit, operator, clear, equals or an unused code. It
  // stalls the input only while its register is full and the queue cannot
  // take another key.
  kpc_qstat_t q_stat;
  logic       push;
  kpc_item_t  push_item;
  logic       pop;
  kpc_item_t  pop_item;

  kpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_code  (key_code),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // A four-deep queue lets keys keep arriving while the back end is busy
  // with a multiply or divide, or while the output is stalled.
  kpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // The back end executes one key at a time. Digits, operators, clear, add
  // and subtract finish in the cycle the key is taken; multiply and divide
  // iterate one bit per cycle. Each key produces exactly one output
  // transaction, held in a register; the next key is taken only when that register is
  // empty or its result is being taken downstream in the same cycle.
  kpc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_stat           (q_stat),
    .pop              (pop),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .shown_value      (shown_value),
    .pending_operator (pending_operator),
    .divide_by_zero   (divide_by_zero)
  );

endmodule

// ===== src/kpc_checker.sv =====
// Port-level checker for the keypad calculator, bound to the top level.
// Depends on kpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kpc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [kpc_pkg::VALUE_W-1:0] shown_value,
  input logic [kpc_pkg::OP_W-1:0]          pending_operator,
  input logic                              divide_by_zero
);
  import kpc_pkg::*;

  `KPC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(shown_value) && $stable(pending_operator) && $stable(divide_by_zero), "stalled output transaction changed")
  `KPC_ASSERT_RST(a_reset_out, rst |=> !out_valid, "output valid after reset")
  `KPC_ASSERT_RST(a_reset_in, rst |=> !in_stall, "input stalled after reset")
  `KPC_ASSERT(a_dbz_op, out_valid && divide_by_zero |-> pending_operator == OP_DIV, "divide by zero flagged without pending divide")
  `KPC_ASSERT(a_op_range, out_valid |-> pending_operator <= OP_DIV, "pending operator code out of range")

endmodule

bind keypad_four_function_calculator kpc_checker u_kpc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .shown_value      (shown_value),
  .pending_operator (pending_operator),
  .divide_by_zero   (divide_by_zero)
);
